/* hw/rtl/vt4_pkg.sv */
// Shared types, constants and helpers for the 4x4 vertex transform.
package vt4_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAT_N         = 16;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_POINT = 2'd1,
    CMD_VEC4  = 2'd2
  } vt4_cmd_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } vt4_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               div_zero;
    logic               overflow;
  } vt4_out_t;

  // one transform job, with the matrix as it stood when the item arrived
  typedef struct packed {
    logic                        point;
    logic signed [31:0]          x;
    logic signed [31:0]          y;
    logic signed [31:0]          z;
    logic signed [31:0]          w;
    logic [MAT_N-1:0][31:0]      mat;
  } vt4_job_t;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

/* hw/rtl/vt4_front.sv */
// Front end: accepts items, applies matrix loads, forwards transform jobs.
module vt4_front #(
  parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vt4_pkg::vt4_in_t   in_data,
  input  logic               q_full,
  output logic               push,
  output vt4_pkg::vt4_job_t  push_job
);

  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  logic [vt4_pkg::MAT_N-1:0][31:0] mat;
  logic accept;
  logic is_load;
  logic is_xform;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_load  = (in_data.cmd == vt4_pkg::CMD_LOAD);
  assign is_xform = (in_data.cmd == vt4_pkg::CMD_POINT) || (in_data.cmd == vt4_pkg::CMD_VEC4);
  assign push     = accept && is_xform;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          mat[c*4+r] <= (c == r) ? ONE : 32'd0;
        end
      end
    end else if (accept && is_load) begin
      mat[in_data.elem_index] <= in_data.elem_value;
    end
  end

  always_comb begin
    push_job.point = (in_data.cmd == vt4_pkg::CMD_POINT);
    push_job.x     = in_data.in_x;
    push_job.y     = in_data.in_y;
    push_job.z     = in_data.in_z;
    push_job.w     = in_data.in_w;
    push_job.mat   = mat;
  end

endmodule

/* hw/rtl/vt4_queue.sv */
// Two-entry job queue between front and back end.
module vt4_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vt4_pkg::vt4_job_t  push_job,
  output logic               full,
  output logic               pop_valid,
  input  logic               pop_ready,
  output vt4_pkg::vt4_job_t  pop_job
);

  vt4_pkg::vt4_job_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

/* hw/rtl/vt4_back.sv */
// Back end: product array, row sums, pipelined divider and result register.
module vt4_back #(
  parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  vt4_pkg::vt4_job_t  job,
  output logic               out_valid,
  input  logic               out_ready,
  output vt4_pkg::vt4_out_t  out_data
);

  localparam int NB = vt4_pkg::DATA_W + FRAC_BITS;

  logic advance;
  assign advance   = !out_valid || out_ready;
  assign job_ready = advance;

  // stage 1: products
  logic signed [31:0] vec [4];
  assign vec[0] = job.x;
  assign vec[1] = job.y;
  assign vec[2] = job.z;
  assign vec[3] = job.w;

  logic               s1_valid;
  logic               s1_point;
  logic signed [63:0] s1_prod  [4][4];
  logic signed [31:0] s1_trans [4];

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (advance) s1_valid <= job_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_point <= job.point;
      for (int r = 0; r < 4; r++) begin
        s1_trans[r] <= $signed(job.mat[12+r]);
        for (int c = 0; c < 4; c++) begin
          s1_prod[r][c] <= 64'($signed(job.mat[c*4+r])) * 64'(vec[c]);
        end
      end
    end
  end

  // stage 2: scale and saturate each product; a point takes the translation as its w term
  logic signed [63:0] shp    [4][4];
  logic signed [31:0] term_n [4][4];
  logic [3:0]         povf_n;

  always_comb begin
    povf_n = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        shp[r][c]    = s1_prod[r][c] >>> FRAC_BITS;
        term_n[r][c] = shp[r][c][31:0];
        if (c == 3 && s1_point) begin
          term_n[r][c] = s1_trans[r];
        end else if ((shp[r][c][63:31] != '0) && (shp[r][c][63:31] != '1)) begin
          povf_n[r]    = 1'b1;
          term_n[r][c] = shp[r][c][63] ? vt4_pkg::S32_MIN : vt4_pkg::S32_MAX;
        end
      end
    end
  end

  logic               s2_valid;
  logic               s2_point;
  logic               s2_ovf;
  logic signed [31:0] s2_term [4][4];

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (advance) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_point <= s1_point;
      s2_ovf   <= |povf_n;
      s2_term  <= term_n;
    end
  end

  // stage 3: row sums
  logic signed [33:0] sum_n  [4];
  logic signed [31:0] row_n  [4];
  logic [3:0]         sovf_n;

  always_comb begin
    sovf_n = '0;
    for (int r = 0; r < 4; r++) begin
      sum_n[r] = 34'(s2_term[r][0]) + 34'(s2_term[r][1])
               + 34'(s2_term[r][2]) + 34'(s2_term[r][3]);
      row_n[r] = sum_n[r][31:0];
      if ((sum_n[r][33:31] != 3'b000) && (sum_n[r][33:31] != 3'b111)) begin
        sovf_n[r] = 1'b1;
        row_n[r]  = sum_n[r][33] ? vt4_pkg::S32_MIN : vt4_pkg::S32_MAX;
      end
    end
  end

  logic               s3_valid;
  logic               s3_point;
  logic               s3_ovf;
  logic signed [31:0] s3_r [4];

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (advance) s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_point <= s2_point;
      s3_ovf   <= s2_ovf || (|sovf_n);
      s3_r     <= row_n;
    end
  end

  // divider pipeline: stage 0 loads magnitudes, one quotient bit per stage after
  logic               dv_valid [NB+1];
  logic               dv_point [NB+1];
  logic               dv_ovf   [NB+1];
  logic signed [31:0] dv_r     [NB+1][4];
  logic [31:0]        dv_d     [NB+1];
  logic [31:0]        dv_rem   [NB+1][3];
  logic [NB-1:0]      dv_dq    [NB+1][3];

  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else if (advance) dv_valid[0] <= s3_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dv_point[0] <= s3_point;
      dv_ovf[0]   <= s3_ovf;
      dv_r[0]     <= s3_r;
      dv_d[0]     <= vt4_pkg::abs32(s3_r[3]);
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= '0;
        dv_dq[0][i]  <= {vt4_pkg::abs32(s3_r[i]), {FRAC_BITS{1'b0}}};
      end
    end
  end

  for (genvar k = 1; k <= NB; k++) begin : g_div
    logic [2:0][32:0]   t;
    logic [2:0]         ge;
    logic [2:0][31:0]   rem_n;
    logic [2:0][NB-1:0] dq_n;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]     = {dv_rem[k-1][i], dv_dq[k-1][i][NB-1]};
        ge[i]    = (t[i] >= {1'b0, dv_d[k-1]});
        rem_n[i] = ge[i] ? 32'(t[i] - {1'b0, dv_d[k-1]}) : t[i][31:0];
        dq_n[i]  = {dv_dq[k-1][i][NB-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_valid[k] <= 1'b0;
      else if (advance) dv_valid[k] <= dv_valid[k-1];
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dv_point[k] <= dv_point[k-1];
        dv_ovf[k]   <= dv_ovf[k-1];
        dv_r[k]     <= dv_r[k-1];
        dv_d[k]     <= dv_d[k-1];
        for (int i = 0; i < 3; i++) begin
          dv_rem[k][i] <= rem_n[i];
          dv_dq[k][i]  <= dq_n[i];
        end
      end
    end
  end

  // result: sign, saturation and zero-w handling
  logic signed [31:0] lane [3];
  logic [2:0]         qovf;
  logic               neg;
  logic [NB-1:0]      q;
  logic               zero_w;
  vt4_pkg::vt4_out_t  res;

  always_comb begin
    qovf   = '0;
    neg    = 1'b0;
    q      = '0;
    zero_w = (dv_d[NB] == 32'd0);
    for (int i = 0; i < 3; i++) begin
      lane[i] = dv_r[NB][i];
      if (dv_point[NB]) begin
        if (zero_w) begin
          if (dv_r[NB][i] == 32'sd0) lane[i] = 32'sd0;
          else lane[i] = dv_r[NB][i][31] ? vt4_pkg::S32_MIN : vt4_pkg::S32_MAX;
        end else begin
          neg = dv_r[NB][i][31] ^ dv_r[NB][3][31];
          q   = dv_dq[NB][i];
          if (neg) begin
            if ((q[NB-1:32] != '0) || (q[31] && (q[30:0] != '0))) begin
              qovf[i] = 1'b1;
              lane[i] = vt4_pkg::S32_MIN;
            end else begin
              lane[i] = ~q[31:0] + 32'd1;
            end
          end else begin
            if (q[NB-1:31] != '0) begin
              qovf[i] = 1'b1;
              lane[i] = vt4_pkg::S32_MAX;
            end else begin
              lane[i] = q[31:0];
            end
          end
        end
      end
    end
    res.out_x    = lane[0];
    res.out_y    = lane[1];
    res.out_z    = lane[2];
    res.out_w    = dv_r[NB][3];
    res.div_zero = dv_point[NB] && zero_w;
    res.overflow = dv_ovf[NB] || (|qovf);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= dv_valid[NB];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

/* hw/rtl/vertex_transform_4x4.sv */
// Top level of the 4x4 homogeneous vertex transform with perspective divide.
//
// Input channel (in_valid/in_ready/in_data): cmd LOAD writes one matrix element
// (column-major, col*4+row) and gives no result; POINT transforms (x,y,z,1) and
// divides x, y, z by the computed w; VEC4 returns the full product M*(x,y,z,w).
// Other cmd codes are dropped. Output channel (out_valid/out_ready/out_data)
// carries one result per transform item, in order.
// Throughput: one item per cycle while the job queue is not full, loads and
// transforms mixed freely. Path: queue, product, scale, row-sum, divider load,
// FRAC_BITS + 32 divider stages of one quotient bit each, output register.
// A load takes effect for every transform accepted after it.
// Reset: matrix returns to identity, queue and pipeline empty.
// While a result waits with out_ready low the whole back pipeline holds; the
// two-entry job queue keeps taking items until it fills, then in_ready drops.
module vertex_transform_4x4 #(
  parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vt4_pkg::vt4_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vt4_pkg::vt4_out_t  out_data
);

  logic              q_full;
  logic              push;
  vt4_pkg::vt4_job_t push_job;
  logic              job_valid;
  logic              job_ready;
  vt4_pkg::vt4_job_t job;

  vt4_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  vt4_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop_valid (job_valid),
    .pop_ready (job_ready),
    .pop_job   (job)
  );

  vt4_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_out_after_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_div_zero_w: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.div_zero |-> out_data.out_w == 32'sd0)
    else $error("div_zero with nonzero w");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into full queue");
`endif

endmodule
